@@ hw/rtl/drs_pkg.sv @@
// Shared types and field widths for the dependency readiness scoreboard.
`default_nettype none

package drs_pkg;

   // Field widths of the request, response and control register words.
   localparam int unsigned TypeW        = 2;
   localparam int unsigned ConsumerIdxW = 5;
   localparam int unsigned ProducerIdW  = 6;
   localparam int unsigned CountW       = 6;

   typedef enum logic [TypeW-1:0] {
      REQ_BIND   = 2'd0,
      REQ_FINISH = 2'd1,
      REQ_READY  = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

endpackage

`default_nettype wire

@@ hw/rtl/dependency_readiness_scoreboard_unit.sv @@
// Top level of the dependency readiness scoreboard: row RAM, scan sequencer and result buffer.
//
//   Channel   Ports                                   Direction  Moves
//   request   req_valid, req_stall, req_type,         in         one command word
//             req_consumer_index, req_producer_id
//   response  rsp_valid, rsp_stall,                   out        one ready consumer word
//             rsp_ready_consumer, rsp_last
//   control   csr_wr_en, csr_wr_data                  in         consumer count register
//
// A bind word reads the row, then writes it back; a clear word needs no row RAM access.
// A finish or ready word sweeps the rows in use through the row RAM, one row per cycle,
// reading each row while the row before it is evaluated and written back.
// The sweep pauses while a found consumer waits behind a stalled response word.
// Synchronous reset empties the scoreboard at once (per-row valid bits), so no
// clearing pass is needed; the request side stalls until the current word is finished.
`default_nettype none

module dependency_readiness_scoreboard_unit #(
   parameter int unsigned MAX_CONSUMERS = 32,
   parameter int unsigned MAX_PRODUCERS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [drs_pkg::TypeW-1:0]           req_type,
   input  wire logic [drs_pkg::ConsumerIdxW-1:0]    req_consumer_index,
   input  wire logic [drs_pkg::ProducerIdW-1:0]     req_producer_id,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [drs_pkg::ConsumerIdxW-1:0]    rsp_ready_consumer,
   output logic                                     rsp_last,
   input  wire logic                                csr_wr_en,
   input  wire logic [drs_pkg::CountW-1:0]          csr_wr_data
);

   import drs_pkg::*;

   localparam int unsigned CW = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
   localparam int unsigned NW = $clog2(MAX_CONSUMERS + 1);
   localparam int unsigned PW = (MAX_PRODUCERS > 1) ? $clog2(MAX_PRODUCERS) : 1;
   localparam logic [6:0] MaxCons7 = 7'(MAX_CONSUMERS);
   localparam logic [6:0] MaxProd7 = 7'(MAX_PRODUCERS);
   localparam logic [MAX_PRODUCERS-1:0] ProdOne = MAX_PRODUCERS'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BIND_WR,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // Registers.
   state_type                 state_ff, state_in;
   req_kind_type              kind_ff, kind_in;
   logic [CW-1:0]             ci_ff, ci_in;
   logic [PW-1:0]             pid_ff, pid_in;
   logic [NW-1:0]             issue_ff, issue_in;
   logic                      eval_valid_ff, eval_valid_in;
   logic [CW-1:0]             eval_idx_ff, eval_idx_in;
   logic [MAX_CONSUMERS-1:0]  emitted_ff, emitted_in;
   logic [MAX_CONSUMERS-1:0]  row_valid_ff, row_valid_in;
   logic                      hold_valid_ff, hold_valid_in;
   logic [ConsumerIdxW-1:0]   hold_idx_ff, hold_idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ConsumerIdxW-1:0]   rsp_consumer_ff, rsp_consumer_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [CountW-1:0]         count_ff, count_in;

   // Combinational signals.
   logic                      req_acc;
   req_kind_type              req_kind;
   logic [CW-1:0]             req_ci;
   logic                      ci_ok;
   logic                      pid_ok;
   logic [6:0]                count7;
   logic [6:0]                active7;
   logic [NW-1:0]             active_n;
   logic                      out_free;
   logic                      scan_hold;
   logic [MAX_PRODUCERS-1:0]  bit_mask;
   logic [MAX_PRODUCERS-1:0]  ram_rdata;
   logic [MAX_PRODUCERS-1:0]  bind_row;
   logic [MAX_PRODUCERS-1:0]  eval_row;
   logic [MAX_PRODUCERS-1:0]  eval_new_row;
   logic                      eval_found;
   logic                      eval_write;
   logic                      ram_we;
   logic [CW-1:0]             ram_waddr;
   logic [MAX_PRODUCERS-1:0]  ram_wdata;
   logic                      ram_re;
   logic [CW-1:0]             ram_raddr;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign req_kind  = req_kind_type'(req_type);
   assign req_ci    = CW'(req_consumer_index);
   assign ci_ok     = ({2'b00, req_consumer_index} < MaxCons7);
   assign pid_ok    = ({1'b0, req_producer_id} < MaxProd7);

   // Consumers in use: the register value, capped at the table depth.
   assign count7   = {1'b0, count_ff};
   assign active7  = (count7 > MaxCons7) ? MaxCons7 : count7;
   assign active_n = active7[NW-1:0];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // A found consumer can only leave the hold slot through a free response register.
   assign scan_hold = hold_valid_ff && !out_free;
   assign bit_mask  = ProdOne << pid_ff;

   // Rows that were never written since the last clear read as empty.
   assign bind_row     = row_valid_ff[ci_ff] ? ram_rdata : '0;
   assign eval_row     = row_valid_ff[eval_idx_ff] ? ram_rdata : '0;
   assign eval_new_row = eval_row & ~bit_mask;

   always_comb begin
      eval_found = 1'b0;
      eval_write = 1'b0;
      if (state_ff == ST_SCAN && eval_valid_ff && !emitted_ff[eval_idx_ff]) begin
         if (kind_ff == REQ_FINISH) begin
            eval_found = (eval_row == '0);
         end else begin
            eval_write = ((eval_row & bit_mask) != '0);
            eval_found = eval_write && (eval_new_row == '0);
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      kind_in         = kind_ff;
      ci_in           = ci_ff;
      pid_in          = pid_ff;
      issue_in        = issue_ff;
      eval_valid_in   = eval_valid_ff;
      eval_idx_in     = eval_idx_ff;
      emitted_in      = emitted_ff;
      row_valid_in    = row_valid_ff;
      hold_valid_in   = hold_valid_ff;
      hold_idx_in     = hold_idx_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_consumer_in = rsp_consumer_ff;
      rsp_last_in     = rsp_last_ff;
      count_in        = count_ff;
      ram_we          = 1'b0;
      ram_waddr       = ci_ff;
      ram_wdata       = bind_row | bit_mask;
      ram_re          = 1'b0;
      ram_raddr       = req_ci;

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               kind_in = req_kind;
               ci_in   = req_ci;
               pid_in  = PW'(req_producer_id);
               unique case (req_kind)
                  REQ_BIND: begin
                     if (ci_ok && pid_ok && !emitted_ff[req_ci]) begin
                        ram_re   = 1'b1;
                        state_in = ST_BIND_WR;
                     end
                  end
                  REQ_FINISH: begin
                     issue_in      = '0;
                     eval_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  REQ_READY: begin
                     if (pid_ok) begin
                        issue_in      = '0;
                        eval_valid_in = 1'b0;
                        state_in      = ST_SCAN;
                     end
                  end
                  REQ_CLEAR: begin
                     emitted_in   = '0;
                     row_valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_BIND_WR: begin
            ram_we            = 1'b1;
            ram_waddr         = ci_ff;
            ram_wdata         = bind_row | bit_mask;
            row_valid_in[ci_ff] = 1'b1;
            state_in          = ST_IDLE;
         end

         ST_SCAN: begin
            if (!scan_hold) begin
               ram_waddr = eval_idx_ff;
               ram_wdata = eval_new_row;
               if (eval_write) begin
                  ram_we = 1'b1;
               end
               if (eval_found) begin
                  emitted_in[eval_idx_ff] = 1'b1;
                  // The previous find is not the final one, so it leaves with last clear.
                  if (hold_valid_ff) begin
                     rsp_valid_in    = 1'b1;
                     rsp_consumer_in = hold_idx_ff;
                     rsp_last_in     = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_idx_in   = ConsumerIdxW'(eval_idx_ff);
               end
               if (issue_ff < active_n) begin
                  ram_re        = 1'b1;
                  ram_raddr     = issue_ff[CW-1:0];
                  issue_in      = issue_ff + 1'b1;
                  eval_valid_in = 1'b1;
                  eval_idx_in   = issue_ff[CW-1:0];
               end else begin
                  eval_valid_in = 1'b0;
                  if (!eval_valid_ff) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end

         ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_consumer_in = hold_idx_ff;
               rsp_last_in     = 1'b1;
               hold_valid_in   = 1'b0;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         kind_ff         <= REQ_BIND;
         ci_ff           <= '0;
         pid_ff          <= '0;
         issue_ff        <= '0;
         eval_valid_ff   <= 1'b0;
         eval_idx_ff     <= '0;
         emitted_ff      <= '0;
         row_valid_ff    <= '0;
         hold_valid_ff   <= 1'b0;
         hold_idx_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
         rsp_consumer_ff <= '0;
         rsp_last_ff     <= 1'b0;
         count_ff        <= '0;
      end else begin
         state_ff        <= state_in;
         kind_ff         <= kind_in;
         ci_ff           <= ci_in;
         pid_ff          <= pid_in;
         issue_ff        <= issue_in;
         eval_valid_ff   <= eval_valid_in;
         eval_idx_ff     <= eval_idx_in;
         emitted_ff      <= emitted_in;
         row_valid_ff    <= row_valid_in;
         hold_valid_ff   <= hold_valid_in;
         hold_idx_ff     <= hold_idx_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_consumer_ff <= rsp_consumer_in;
         rsp_last_ff     <= rsp_last_in;
         count_ff        <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ready_consumer = rsp_consumer_ff;
   assign rsp_last           = rsp_last_ff;

   drs_ram #(
      .WIDTH (MAX_PRODUCERS),
      .DEPTH (MAX_CONSUMERS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // No found consumer may be left behind when a new word can be taken.
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("hold slot occupied while idle");

   // Only the sweep keeps a row under evaluation.
   a_eval_in_scan: assert property (@(posedge clock) disable iff (reset)
      eval_valid_ff |-> (state_ff == ST_SCAN))
      else $error("row evaluation outside of a sweep");

   // The sweep writes back the row behind the one it reads.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("row RAM read and write hit the same row");

   // A consumer once reported stays reported until the tables are cleared.
   a_emitted_sticky: assert property (@(posedge clock) disable iff (reset)
      !(req_acc && req_kind == REQ_CLEAR)
      |=> ((emitted_ff & $past(emitted_ff)) == $past(emitted_ff)))
      else $error("emitted flag dropped without a clear");

endmodule

`default_nettype wire

@@ hw/rtl/drs_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module drs_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic                                       rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
